// ===== rtl/assert_macros.svh =====
// assertion macros used by the equalizer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(name, clk_sig, rst_n_sig, ante, cons) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("same-cycle property violated");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(name, clk_sig, rst_n_sig, ante, cons) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("next-cycle property violated");

`endif

// ===== rtl/tbeq_pkg.sv =====
// shared types, widths and register codes of the three-band equalizer
package tbeq_pkg;

	// sample format and defaults
	localparam int SAMPLE_BITS      = 24;
	localparam int MAX_CHANNELS_DEF = 8;

	// shared multiplier widths: band operand times zero-extended 16-bit coefficient
	localparam int MUL_A_W = SAMPLE_BITS + 2;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CNT_W      = 4;
	localparam int COEF_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_COUNT  = 3'd0,
		REG_LOWPASS_ALPHA  = 3'd1,
		REG_HIGHPASS_ALPHA = 3'd2,
		REG_LOW_GAIN       = 3'd3,
		REG_MID_GAIN       = 3'd4,
		REG_HIGH_GAIN      = 3'd5
	} cfg_reg_t;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// input request
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] in_sample;
		logic                          restart_block;
	} src_t;

	// output request
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] eq_sample;
		logic [2:0]                    out_channel;
		logic                          status;
	} eq_t;

	// per-channel filter history
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] low;
		logic signed [SAMPLE_BITS-1:0] hp_in;
		logic signed [SAMPLE_BITS-1:0] hp_out;
	} chan_state_t;

	// update request toward the channel store
	typedef struct packed {
		logic        wr_en;
		logic        clr_all;
		chan_state_t data;
	} store_req_t;

endpackage

// ===== rtl/tbeq_mul.sv =====
// shared signed multiplier with registered product
module tbeq_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [tbeq_pkg::MUL_A_W-1:0] a,
	input  logic signed [tbeq_pkg::MUL_B_W-1:0] b,
	output logic signed [tbeq_pkg::PROD_W-1:0]  prod_q
);

	// product register, held while the sequencer is not multiplying
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= tbeq_pkg::PROD_W'(a) * tbeq_pkg::PROD_W'(b);
		end
	end

endmodule

// ===== rtl/tbeq_store.sv =====
// per-channel filter history with started flags
module tbeq_store #(
	parameter int MAX_CHANNELS = tbeq_pkg::MAX_CHANNELS_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic [(MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1)-1:0] rd_ch,
	input  logic [(MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1)-1:0] wr_ch,
	input  tbeq_pkg::store_req_t                                req,
	output logic                                                started,
	output tbeq_pkg::chan_state_t                               hist
);

	tbeq_pkg::chan_state_t  hist_q [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] started_q;

	// started flags: restart clears all, a finished sample sets its channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= '0;
		end else if (req.clr_all) begin
			started_q <= '0;
		end else if (req.wr_en) begin
			started_q[wr_ch] <= 1'b1;
		end
	end

	// history values, only meaningful once the channel has started
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			hist_q[wr_ch] <= req.data;
		end
	end

	assign started = started_q[rd_ch];
	assign hist    = hist_q[rd_ch];

endmodule

// ===== rtl/three_band_equalizer.sv =====
// three-band equalizer top level: config registers, sequencer and datapath
//
// channel | signals                        | request
// --------+--------------------------------+----------------------------------
// src     | src_valid src_ready src_data   | one sample and its restart flag
// eq      | eq_valid eq_ready eq_data      | equalized sample, channel, status
// cfg     | cfg_we cfg_index cfg_wdata     | register write, no handshake
//
// from acceptance to the next ready, a sample makes five passes through
// the one shared multiplier (two filter products, three gain products) plus a
// final round and saturate step. the result sits in an output register, so a
// stalled eq side only holds the final step once the previous result is still
// unread. reset clears the channel counter, started flags and registers to their
// defaults; there is no clearing pass.

`include "assert_macros.svh"

module three_band_equalizer #(
	parameter int MAX_CHANNELS = tbeq_pkg::MAX_CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              src_valid,
	output logic                              src_ready,
	input  tbeq_pkg::src_t                    src_data,
	output logic                              eq_valid,
	input  logic                              eq_ready,
	output tbeq_pkg::eq_t                     eq_data,
	input  logic                              cfg_we,
	input  logic [tbeq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tbeq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int S     = tbeq_pkg::SAMPLE_BITS;
	localparam int CH_W  = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
	localparam int ACC_W = S + 21;
	localparam int PW    = tbeq_pkg::PROD_W;
	localparam int AW    = tbeq_pkg::MUL_A_W;
	localparam int BW    = tbeq_pkg::MUL_B_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_LOW,
		S_MUL_HIGH,
		S_MUL_LG,
		S_MUL_HG,
		S_MUL_MG,
		S_FIN
	} state_t;

	state_t state_q;

	// configuration registers
	logic [tbeq_pkg::CNT_W-1:0]  chan_count_q;
	logic [tbeq_pkg::COEF_W-1:0] lp_alpha_q;
	logic [tbeq_pkg::COEF_W-1:0] hp_alpha_q;
	logic [tbeq_pkg::COEF_W-1:0] low_gain_q;
	logic [tbeq_pkg::COEF_W-1:0] mid_gain_q;
	logic [tbeq_pkg::COEF_W-1:0] high_gain_q;

	// sequencer and datapath registers
	logic [CH_W-1:0]         cur_q;
	logic [CH_W-1:0]         ch_q;
	logic signed [S-1:0]     x_q;
	logic signed [S-1:0]     low_q;
	logic signed [S-1:0]     high_q;
	logic signed [AW-1:0]    hin_q;
	logic signed [AW-1:0]    mid_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    eq_valid_q;
	tbeq_pkg::eq_t           eq_q;

	// combinational values
	logic [tbeq_pkg::CNT_W-1:0] eff_cnt;
	logic [CH_W-1:0]            cur_start;
	logic [CH_W-1:0]            ch_sel;
	logic [CH_W-1:0]            ch_next;
	logic                       accept;
	logic                       slot_free;
	logic                       started;
	tbeq_pkg::chan_state_t      hist;
	tbeq_pkg::store_req_t       store_req;
	logic                       mul_en;
	logic signed [AW-1:0]       mul_a;
	logic signed [BW-1:0]       mul_b;
	logic signed [PW-1:0]       prod_q;
	logic signed [PW-1:0]       prod_rnd;
	logic signed [PW-1:0]       prod_sh;
	logic signed [ACC_W-1:0]    low_sum;
	logic signed [ACC_W-1:0]    high_ext;
	logic signed [ACC_W-1:0]    mix_sum;
	logic signed [ACC_W-1:0]    mix_sh;

	// clamp a wide value to the sample range
	function automatic logic signed [S-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
		logic signed [S-1:0] r;
		if (v > ACC_W'(tbeq_pkg::SAMPLE_MAX)) begin
			r = tbeq_pkg::SAMPLE_MAX;
		end else if (v < ACC_W'(tbeq_pkg::SAMPLE_MIN)) begin
			r = tbeq_pkg::SAMPLE_MIN;
		end else begin
			r = v[S-1:0];
		end
		return r;
	endfunction

	function automatic logic out_of_range(input logic signed [ACC_W-1:0] v);
		return (v > ACC_W'(tbeq_pkg::SAMPLE_MAX)) || (v < ACC_W'(tbeq_pkg::SAMPLE_MIN));
	endfunction

	// effective channel count and channel pick
	always_comb begin
		eff_cnt = chan_count_q;
		if (chan_count_q == '0) begin
			eff_cnt = tbeq_pkg::CNT_W'(1);
		end else if (32'(chan_count_q) > MAX_CHANNELS) begin
			eff_cnt = tbeq_pkg::CNT_W'(MAX_CHANNELS);
		end
		cur_start = src_data.restart_block ? '0 : cur_q;
		ch_sel    = (32'(cur_start) >= 32'(eff_cnt)) ? '0 : cur_start;
		ch_next   = (32'(ch_q) + 32'd1 >= 32'(eff_cnt)) ? '0 : CH_W'(32'(ch_q) + 32'd1);
	end

	assign src_ready = (state_q == S_IDLE);
	assign accept    = src_valid && src_ready;
	assign slot_free = !eq_valid_q || eq_ready;
	assign eq_valid  = eq_valid_q;
	assign eq_data   = eq_q;

	// operand select for the shared multiplier
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			S_MUL_LOW: begin
				mul_a = AW'(x_q) - AW'(hist.low);
				mul_b = BW'(lp_alpha_q);
			end
			S_MUL_HIGH: begin
				mul_a = hin_q;
				mul_b = BW'(hp_alpha_q);
			end
			S_MUL_LG: begin
				mul_a = AW'(low_q);
				mul_b = BW'(low_gain_q);
			end
			S_MUL_HG: begin
				mul_a = AW'(high_q);
				mul_b = BW'(high_gain_q);
			end
			S_MUL_MG: begin
				mul_a = mid_q;
				mul_b = BW'(mid_gain_q);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	tbeq_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// filter products: round half up, then drop the 16 fraction bits
	assign prod_rnd = prod_q + PW'(32768);
	assign prod_sh  = prod_rnd >>> 16;
	assign low_sum  = ACC_W'(hist.low) + ACC_W'(prod_sh);
	assign high_ext = ACC_W'(prod_sh);

	// final mix: rounding constant already sits in the accumulator
	assign mix_sum = acc_q + ACC_W'(prod_q);
	assign mix_sh  = mix_sum >>> 12;

	// channel store requests: clear on restart, update when the sample finishes
	always_comb begin
		store_req.clr_all     = accept && src_data.restart_block;
		store_req.wr_en       = (state_q == S_FIN) && slot_free;
		store_req.data.low    = low_q;
		store_req.data.hp_in  = x_q;
		store_req.data.hp_out = high_q;
	end

	tbeq_store #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_ch   (ch_q),
		.wr_ch   (ch_q),
		.req     (store_req),
		.started (started),
		.hist    (hist)
	);

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count_q <= tbeq_pkg::CNT_W'(1);
			lp_alpha_q   <= tbeq_pkg::COEF_W'(32768);
			hp_alpha_q   <= tbeq_pkg::COEF_W'(32768);
			low_gain_q   <= tbeq_pkg::COEF_W'(4096);
			mid_gain_q   <= tbeq_pkg::COEF_W'(4096);
			high_gain_q  <= tbeq_pkg::COEF_W'(4096);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbeq_pkg::REG_CHANNEL_COUNT:  chan_count_q <= cfg_wdata[tbeq_pkg::CNT_W-1:0];
				tbeq_pkg::REG_LOWPASS_ALPHA:  lp_alpha_q   <= cfg_wdata;
				tbeq_pkg::REG_HIGHPASS_ALPHA: hp_alpha_q   <= cfg_wdata;
				tbeq_pkg::REG_LOW_GAIN:       low_gain_q   <= cfg_wdata;
				tbeq_pkg::REG_MID_GAIN:       mid_gain_q   <= cfg_wdata;
				tbeq_pkg::REG_HIGH_GAIN:      high_gain_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer state, channel counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cur_q      <= '0;
			eq_valid_q <= 1'b0;
			eq_q       <= '0;
		end else begin
			// output valid: set by a finished sample, cleared once taken
			if ((state_q == S_FIN) && slot_free) begin
				eq_valid_q <= 1'b1;
			end else if (eq_valid_q && eq_ready) begin
				eq_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MUL_LOW;
						if (src_data.restart_block) begin
							cur_q <= '0;
						end
					end
				end
				S_MUL_LOW:  state_q <= S_MUL_HIGH;
				S_MUL_HIGH: state_q <= S_MUL_LG;
				S_MUL_LG:   state_q <= S_MUL_HG;
				S_MUL_HG:   state_q <= S_MUL_MG;
				S_MUL_MG:   state_q <= S_FIN;
				S_FIN: begin
					if (slot_free) begin
						eq_q.eq_sample   <= sat_sample(mix_sh);
						eq_q.out_channel <= 3'(ch_q);
						eq_q.status      <= out_of_range(mix_sh);
						cur_q            <= ch_next;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					x_q  <= src_data.in_sample;
					ch_q <= ch_sel;
				end
			end
			S_MUL_LOW: begin
				hin_q <= AW'(hist.hp_out) + AW'(x_q) - AW'(hist.hp_in);
			end
			S_MUL_HIGH: begin
				// first sample of a channel passes straight to the low band
				low_q <= started ? sat_sample(low_sum) : x_q;
			end
			S_MUL_LG: begin
				high_q <= started ? sat_sample(high_ext) : '0;
			end
			S_MUL_HG: begin
				acc_q <= ACC_W'(prod_q) + ACC_W'(2048);
				mid_q <= AW'(x_q) - AW'(low_q) - AW'(high_q);
			end
			S_MUL_MG: begin
				acc_q <= acc_q + ACC_W'(prod_q);
			end
			default: ;
		endcase
	end

	// checks
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, src_valid && src_ready, !src_ready)
	`ASSERT_NEXT(a_fin_delivers, clk, arst_n, (state_q == S_FIN) && slot_free, eq_valid && (state_q == S_IDLE))
	`ASSERT_SAME(a_chan_in_range, clk, arst_n, state_q == S_FIN, 32'(ch_q) < 32'(eff_cnt))
	`ASSERT_SAME(a_status_saturated, clk, arst_n, eq_valid && eq_data.status, (eq_data.eq_sample == tbeq_pkg::SAMPLE_MAX) || (eq_data.eq_sample == tbeq_pkg::SAMPLE_MIN))

endmodule
